// ----- design/wsm_pkg.sv -----
`default_nettype none

package wsm_pkg;

  localparam int DATA_W    = 16;
  localparam int CFG_W     = 9;
  localparam int CNT_OUT_W = 9;
  localparam int CH_W      = 2;
  localparam int NUM_CH    = 4;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CH_W-1:0]          ch_t;
  typedef logic [CFG_W-1:0]         cfg_t;
  typedef logic [CNT_OUT_W-1:0]     cnt_out_t;
  typedef logic [1:0]               accuracy_t;

  localparam data_t EXCL_MARK = 16'sd999;
  localparam data_t DATA_MAX  = 16'sh7fff;
  localparam data_t DATA_MIN  = 16'sh8000;
  localparam cfg_t  WIN_RESET = 9'd240;

  localparam ch_t CH_TEMPERATURE = 2'd0;
  localparam ch_t CH_QUALITY     = 2'd3;

  localparam accuracy_t ACC_STABILISING = 2'd0;

endpackage

`default_nettype wire

// ----- design/wsm_if.sv -----
`default_nettype none

interface wsm_in_if;
  logic                  valid;
  logic                  ready;
  wsm_pkg::data_t        temperature;
  wsm_pkg::data_t        humidity;
  wsm_pkg::data_t        pressure;
  wsm_pkg::data_t        air_quality;
  wsm_pkg::accuracy_t    quality_accuracy;

  modport source (
    output valid, temperature, humidity, pressure, air_quality, quality_accuracy,
    input  ready
  );
  modport sink (
    input  valid, temperature, humidity, pressure, air_quality, quality_accuracy,
    output ready
  );
endinterface

interface wsm_out_if;
  logic                  valid;
  logic                  ready;
  wsm_pkg::ch_t          channel;
  wsm_pkg::data_t        minimum;
  wsm_pkg::data_t        maximum;
  wsm_pkg::data_t        mean;
  wsm_pkg::cnt_out_t     valid_count;
  logic                  last;

  modport source (
    output valid, channel, minimum, maximum, mean, valid_count, last,
    input  ready
  );
  modport sink (
    input  valid, channel, minimum, maximum, mean, valid_count, last,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/wsm_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle, truncates toward zero
module wsm_div #(
  parameter int SW = 25,
  parameter int CW = 9
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [SW-1:0] dividend_i,
  input  wire logic [CW-1:0]        divisor_i,
  output logic                      done_o,
  output logic signed [SW-1:0]      quotient_o
);

  localparam int SCW = $clog2(SW);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [SCW-1:0] step_q, step_d;
  logic [CW-1:0]  rem_q, rem_d;
  logic [SW-1:0]  quo_q, quo_d;
  logic [CW-1:0]  dvs_q, dvs_d;
  logic           neg_q, neg_d;

  logic [CW:0]    rem_sh;
  logic [CW:0]    rem_sub;
  logic           ge;

  assign rem_sh  = {rem_q, quo_q[SW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = SCW'(SW - 1);
      rem_d  = '0;
      quo_d  = dividend_i[SW-1] ? SW'(-dividend_i) : SW'(dividend_i);
      dvs_d  = divisor_i;
      neg_d  = dividend_i[SW-1];
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
      quo_d = {quo_q[SW-2:0], ge};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - SCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? $signed(-quo_q) : $signed(quo_q);

endmodule

`default_nettype wire

// ----- design/windowed_sensor_min_max_mean_core.sv -----
`default_nettype none

// windowed min / max / mean over four sensor channels
// sample_i takes one beat per sample (temperature, humidity, pressure, air quality
// and its accuracy); result_o gives four beats when a window closes, in channel
// order temperature, humidity, pressure, air quality, the last one flagged by last.
// cfg_we_i / cfg_wdata_i write the window length (0 acts as 1, above MAX_WINDOW
// saturates); write it only while the block is idle.
// a sample is taken in the accept cycle, then makes four passes through the shared
// adder and comparators, one per channel; ready is low meanwhile.
// on window close the four channels go one after another through a single shared
// restoring divider, each passing through the divide, wait and output states.
// the first result beat shows once the divider finishes and its quotient is registered.
// a stalled receiver holds the result beat and the block takes no sample until
// all four beats are gone.
// reset sets the window length to 240 and empties the window.
module windowed_sensor_min_max_mean_core #(
  parameter int MAX_WINDOW = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  wsm_in_if.sink                   sample_i,
  wsm_out_if.source                result_o,
  input  wire logic                cfg_we_i,
  input  wire wsm_pkg::cfg_t       cfg_wdata_i
);

  localparam int DW = wsm_pkg::DATA_W;
  localparam int NC = wsm_pkg::NUM_CH;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = DW + CW;
  localparam int LW = (CW > wsm_pkg::CFG_W) ? CW : wsm_pkg::CFG_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACC  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]           state_q, state_d;
  wsm_pkg::cfg_t        win_len_q, win_len_d;
  wsm_pkg::ch_t         ch_q, ch_d;
  logic signed [SW-1:0] sum_q [NC];
  logic signed [SW-1:0] sum_d [NC];
  wsm_pkg::data_t       min_q [NC];
  wsm_pkg::data_t       min_d [NC];
  wsm_pkg::data_t       max_q [NC];
  wsm_pkg::data_t       max_d [NC];
  logic [CW-1:0]        scnt_q, scnt_d;
  logic [CW-1:0]        qcnt_q, qcnt_d;
  logic                 res_valid_q, res_valid_d;

  wsm_pkg::data_t       samp_q [NC];
  wsm_pkg::data_t       samp_d [NC];
  logic                 qinc_q, qinc_d;
  wsm_pkg::ch_t         res_ch_q, res_ch_d;
  wsm_pkg::data_t       res_min_q, res_min_d;
  wsm_pkg::data_t       res_max_q, res_max_d;
  wsm_pkg::data_t       res_mean_q, res_mean_d;
  wsm_pkg::cnt_out_t    res_cnt_q, res_cnt_d;
  logic                 res_last_q, res_last_d;

  logic                 div_start;
  logic                 div_done;
  logic signed [SW-1:0] div_quo;
  logic [CW-1:0]        div_cnt;

  wsm_pkg::data_t       acc_v;
  logic signed [SW-1:0] acc_ext;
  logic [CW-1:0]        scnt_inc;
  logic [LW-1:0]        wl_ext;
  logic [LW-1:0]        len_eff;
  logic                 close_win;
  logic                 is_quality;

  assign is_quality = (ch_q == wsm_pkg::CH_QUALITY);
  assign acc_v      = samp_q[ch_q];
  assign acc_ext    = {{CW{acc_v[DW-1]}}, acc_v};
  assign scnt_inc   = scnt_q + CW'(1);
  assign div_cnt    = is_quality ? qcnt_q : scnt_q;

  // clamp the programmed length into 1..MAX_WINDOW
  always_comb begin
    wl_ext = LW'(win_len_q);
    if (wl_ext == '0) begin
      len_eff = LW'(1);
    end else if (wl_ext > LW'(MAX_WINDOW)) begin
      len_eff = LW'(MAX_WINDOW);
    end else begin
      len_eff = wl_ext;
    end
  end

  assign close_win = (LW'(scnt_inc) >= len_eff);

  always_comb begin
    state_d     = state_q;
    win_len_d   = cfg_we_i ? cfg_wdata_i : win_len_q;
    ch_d        = ch_q;
    sum_d       = sum_q;
    min_d       = min_q;
    max_d       = max_q;
    scnt_d      = scnt_q;
    qcnt_d      = qcnt_q;
    res_valid_d = res_valid_q;
    samp_d      = samp_q;
    qinc_d      = qinc_q;
    res_ch_d    = res_ch_q;
    res_min_d   = res_min_q;
    res_max_d   = res_max_q;
    res_mean_d  = res_mean_q;
    res_cnt_d   = res_cnt_q;
    res_last_d  = res_last_q;
    div_start   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          samp_d[0] = sample_i.temperature;
          samp_d[1] = sample_i.humidity;
          samp_d[2] = sample_i.pressure;
          samp_d[3] = sample_i.air_quality;
          qinc_d    = (sample_i.quality_accuracy != wsm_pkg::ACC_STABILISING) &&
                      (sample_i.air_quality != wsm_pkg::EXCL_MARK);
          ch_d      = wsm_pkg::CH_TEMPERATURE;
          state_d   = ST_ACC;
        end
      end
      ST_ACC: begin
        // one channel per cycle through the shared adder and comparators
        if (!is_quality || qinc_q) begin
          sum_d[ch_q] = sum_q[ch_q] + acc_ext;
          if (acc_v < min_q[ch_q]) begin
            min_d[ch_q] = acc_v;
          end
          if (acc_v > max_q[ch_q]) begin
            max_d[ch_q] = acc_v;
          end
        end
        if (is_quality) begin
          scnt_d = scnt_inc;
          if (qinc_q) begin
            qcnt_d = qcnt_q + CW'(1);
          end
          ch_d    = wsm_pkg::CH_TEMPERATURE;
          state_d = close_win ? ST_DIV : ST_IDLE;
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          res_ch_d   = ch_q;
          res_cnt_d  = wsm_pkg::CNT_OUT_W'(div_cnt);
          res_last_d = is_quality;
          if (div_cnt == '0) begin
            res_min_d  = wsm_pkg::EXCL_MARK;
            res_max_d  = wsm_pkg::EXCL_MARK;
            res_mean_d = wsm_pkg::EXCL_MARK;
          end else begin
            res_min_d  = min_q[ch_q];
            res_max_d  = max_q[ch_q];
            res_mean_d = $signed(div_quo[DW-1:0]);
          end
          res_valid_d = 1'b1;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (result_o.ready) begin
          res_valid_d = 1'b0;
          if (is_quality) begin
            for (int c = 0; c < NC; c++) begin
              sum_d[c] = '0;
              min_d[c] = wsm_pkg::DATA_MAX;
              max_d[c] = wsm_pkg::DATA_MIN;
            end
            scnt_d  = '0;
            qcnt_d  = '0;
            ch_d    = wsm_pkg::CH_TEMPERATURE;
            state_d = ST_IDLE;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = ST_DIV;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_len_q   <= wsm_pkg::WIN_RESET;
      ch_q        <= wsm_pkg::CH_TEMPERATURE;
      scnt_q      <= '0;
      qcnt_q      <= '0;
      res_valid_q <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        sum_q[c] <= '0;
        min_q[c] <= wsm_pkg::DATA_MAX;
        max_q[c] <= wsm_pkg::DATA_MIN;
      end
    end else begin
      state_q     <= state_d;
      win_len_q   <= win_len_d;
      ch_q        <= ch_d;
      scnt_q      <= scnt_d;
      qcnt_q      <= qcnt_d;
      res_valid_q <= res_valid_d;
      sum_q       <= sum_d;
      min_q       <= min_d;
      max_q       <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q     <= samp_d;
    qinc_q     <= qinc_d;
    res_ch_q   <= res_ch_d;
    res_min_q  <= res_min_d;
    res_max_q  <= res_max_d;
    res_mean_q <= res_mean_d;
    res_cnt_q  <= res_cnt_d;
    res_last_q <= res_last_d;
  end

  wsm_div #(
    .SW (SW),
    .CW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q[ch_q]),
    .divisor_i  (div_cnt),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign sample_i.ready       = (state_q == ST_IDLE);
  assign result_o.valid       = res_valid_q;
  assign result_o.channel     = res_ch_q;
  assign result_o.minimum     = res_min_q;
  assign result_o.maximum     = res_max_q;
  assign result_o.mean        = res_mean_q;
  assign result_o.valid_count = res_cnt_q;
  assign result_o.last        = res_last_q;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sample_i.ready && result_o.valid))
    else $error("sample accepted while a result beat is pending");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LW'(scnt_q) <= LW'(MAX_WINDOW)) && (qcnt_q <= scnt_q))
    else $error("sample or quality count out of range");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && result_o.last) |=>
      (scnt_q == '0 && qcnt_q == '0))
    else $error("window not cleared after last beat");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WAIT))
    else $error("divider finished outside of wait");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && !result_o.last) |=>
      (ch_q == $past(result_o.channel) + 2'd1))
    else $error("result channels out of order");
`endif

endmodule

`default_nettype wire
